// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Invariant checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`endif

// ===== sv/jcbw_pkg.sv =====
// Package: constants and types of the BMP stream writer.
`timescale 1ns / 1ps
package jcbw_pkg;
  localparam int MAX_SIZE = 4096;
  localparam int HDR_LEN = 54;
  localparam int CFG_W = 32;
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_SIZE = 2'd0;
  localparam logic [IDX_W-1:0] REG_MIN = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX = 2'd2;

  // Byte source selected by the controller.
  typedef enum logic [1:0] {
    SRC_HDR = 2'd0,
    SRC_PIX = 2'd1,
    SRC_PAD = 2'd2
  } src_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic       load;     // capture sample, start color computation
    logic       step;     // not used by the datapath, which advances its division by itself
    src_t       src;
    logic [5:0] hdr_idx;
    logic [1:0] chan;     // 0=B 1=G 2=R
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic done;           // colors ready
  } sts_t;
endpackage

// ===== sv/jcbw_datapath.sv =====
// Datapath: header bytes, sample normalization, colormap and byte mux.
`timescale 1ns / 1ps
module jcbw_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jcbw_pkg::cmd_t       cmd,
  output jcbw_pkg::sts_t       sts,
  input  logic signed [31:0]   sample,
  input  logic signed [31:0]   min_level,
  input  logic signed [31:0]   max_level,
  input  logic [12:0]          n_sz,
  output logic [7:0]           out_byte
);
  import jcbw_pkg::*;

  // Stage 0: register normalized operands.
  logic signed [36:0] t_r, den_r;
  logic [1:0]         pad;
  logic [31:0]        dsize, fsize;
  logic [15:0]        row_b;
  logic [7:0]         b_r, g_r, r_r;

  // Division unit: q = floor(num*255 / den2), num,den2 < 2^37.
  // Long division bit-serial: 9 quotient bits suffice after clamp check.
  typedef enum logic [2:0] {
    PH_IDLE, PH_SEG, PH_DIV, PH_DONE
  } ph_t;
  ph_t              ph_r;
  logic [1:0]       ch_r;      // channel under division
  logic [46:0]      rem_r;     // remainder
  logic [46:0]      num_r;     // dividend shifting in
  logic [38:0]      dv_r;      // divisor (den2)
  logic [8:0]       q_r;
  logic [5:0]       cnt_r;
  logic signed [37:0] nb_r, ng_r, nr_r; // numerators per channel (<=0 -> 0)
  logic [1:0]       fix_r;     // per-seg code of the channel fixed at 255

  logic signed [37:0] den1;
  logic [47:0] rem_sh;
  logic [46:0] num255;

  assign row_b = 16'(3 * n_sz) + 16'(pad);
  assign pad   = 2'((3'd4 - 3'(2'(3 * n_sz))) & 3'd3);
  assign dsize = 32'(row_b) * 32'(n_sz);
  assign fsize = dsize + 32'(HDR_LEN);

  function automatic logic [7:0] hdr_byte(input logic [5:0] i, input logic [31:0] fs,
                                          input logic [31:0] ds, input logic [12:0] n);
    logic [7:0] v;
    v = 8'd0;
    unique case (i)
      6'd0: v = 8'h42;
      6'd1: v = 8'h4D;
      6'd2: v = fs[7:0];
      6'd3: v = fs[15:8];
      6'd4: v = fs[23:16];
      6'd5: v = fs[31:24];
      6'd10: v = 8'd54;
      6'd14: v = 8'd40;
      6'd18, 6'd22: v = n[7:0];
      6'd19, 6'd23: v = {3'd0, n[12:8]};
      6'd26: v = 8'd1;
      6'd28: v = 8'd24;
      6'd34: v = ds[7:0];
      6'd35: v = ds[15:8];
      6'd36: v = ds[23:16];
      6'd37: v = ds[31:24];
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  assign rem_sh = {rem_r, num_r[46]};
  logic signed [37:0] cur_num;
  always_comb begin
    unique case (ch_r)
      2'd0:    cur_num = nb_r;
      2'd1:    cur_num = ng_r;
      default: cur_num = nr_r;
    endcase
  end
  assign num255 = 47'(cur_num) * 47'd255;
  assign den1 = den_r;

  logic signed [39:0] t8;
  assign t8 = 40'(t_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
    end else begin
      unique case (ph_r)
        // A new request is taken both after reset and once the last colors were used.
        PH_IDLE, PH_DONE: begin
          if (cmd.load) begin
            logic signed [33:0] d, den;
            d   = 34'(sample) - 34'(min_level);
            den = 34'(max_level) - 34'(min_level);
            if (den == 34'sd0) begin
              d = '0; den = 34'sd1;
            end else if (den < 0) begin
              d = -d; den = -den;
            end
            t_r   <= 37'(d) <<< 3;
            den_r <= 37'(den);
            ph_r  <= PH_SEG;
          end
        end
        PH_SEG: begin
          nb_r <= '0; ng_r <= '0; nr_r <= '0;
          b_r <= 8'd0; g_r <= 8'd0; r_r <= 8'd0;
          fix_r <= 2'd0;
          if (t_r <= den_r) begin
            nb_r <= 38'(t_r) + 38'(den_r);
          end else if (t_r <= 37'(3) * den_r) begin
            ng_r <= 38'(t_r) - 38'(den_r);
            fix_r <= 2'd1;
          end else if (t_r <= 37'(5) * den_r) begin
            nr_r <= 38'(t_r) - 38'(3) * 38'(den_r);
            nb_r <= 38'(5) * 38'(den_r) - 38'(t_r);
            fix_r <= 2'd2;
          end else if (t_r <= 37'(7) * den_r) begin
            ng_r <= 38'(7) * 38'(den_r) - 38'(t_r);
            fix_r <= 2'd3;
          end else begin
            nr_r <= 38'(9) * 38'(den_r) - 38'(t_r);
          end
          dv_r <= 39'(den_r) <<< 1;
          ch_r <= 2'd0;
          cnt_r <= '0;
          ph_r <= PH_DIV;
        end
        PH_DIV: begin
          if (cnt_r == 6'd0) begin
            // Load dividend for channel.
            num_r <= (cur_num <= 0) ? 47'd0 : num255;
            rem_r <= '0;
            q_r   <= '0;
            cnt_r <= 6'd1;
          end else begin
            logic [47:0] diff;
            logic        ge;
            diff = rem_sh - {9'd0, dv_r};
            ge   = (rem_sh >= {9'd0, dv_r});
            rem_r <= ge ? diff[46:0] : rem_sh[46:0];
            num_r <= num_r << 1;
            q_r   <= (q_r[8] | (ge & q_r[7])) ? 9'h100 : {q_r[7:0], ge};
            if (cnt_r == 6'd47) begin
              logic [7:0] v;
              logic       sat;
              sat = q_r[8] | (ge & q_r[7]) | (q_r[7] & 1'b0);
              v = (q_r[8] | q_r[7]) ? 8'hFF : {q_r[6:0], ge};
              if (sat) v = 8'hFF;
              unique case (ch_r)
                2'd0: b_r <= (fix_r == 2'd1) ? 8'hFF : v;
                2'd1: g_r <= (fix_r == 2'd2) ? 8'hFF : v;
                default: r_r <= (fix_r == 2'd3) ? 8'hFF : v;
              endcase
              cnt_r <= '0;
              if (ch_r == 2'd2) ph_r <= PH_DONE;
              else ch_r <= ch_r + 2'd1;
            end else begin
              cnt_r <= cnt_r + 6'd1;
            end
          end
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  assign sts.done = (ph_r == PH_DONE);

  always_comb begin
    unique case (cmd.src)
      SRC_HDR: out_byte = hdr_byte(cmd.hdr_idx, fsize, dsize, n_sz);
      SRC_PIX: out_byte = (cmd.chan == 2'd0) ? b_r : (cmd.chan == 2'd1) ? g_r : r_r;
      default: out_byte = 8'd0;
    endcase
  end
  logic unused;
  assign unused = cmd.step ^ ^t8 ^ ^den1 ^ ^rem_sh[47];
endmodule

// ===== sv/jcbw_ctrl.sv =====
// Controller: request sequencing, header/pixel/pad byte order, counters.
`timescale 1ns / 1ps
module jcbw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_run_last,
  output logic           out_image_end,
  input  logic [12:0]    n_sz,
  input  jcbw_pkg::sts_t sts,
  output jcbw_pkg::cmd_t cmd
);
  import jcbw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_HDR, S_WAIT, S_PIX, S_PAD
  } state_t;
  state_t      state_r;
  logic [11:0] col_r, row_r;
  logic [5:0]  hidx_r;
  logic [1:0]  ch_r, padc_r;
  logic [1:0]  pad;
  logic        row_end, last_row, fire;

  assign pad      = 2'((3'd4 - 3'(2'(3 * n_sz))) & 3'd3);
  assign row_end  = 13'(col_r) + 13'd1 >= n_sz;
  assign last_row = 13'(row_r) + 13'd1 >= n_sz;
  assign in_ready = (state_r == S_IDLE);
  assign fire     = out_valid & out_ready;

  always_comb begin
    cmd = '0;
    cmd.load    = in_valid & in_ready;
    cmd.hdr_idx = hidx_r;
    cmd.chan    = ch_r;
    unique case (state_r)
      S_HDR:   cmd.src = SRC_HDR;
      S_PIX:   cmd.src = SRC_PIX;
      default: cmd.src = SRC_PAD;
    endcase
    out_valid = (state_r == S_HDR) || (state_r == S_PIX) || (state_r == S_PAD);
    out_run_last = ((state_r == S_PIX) && ch_r == 2'd2 && !(row_end && pad != 0)) ||
                   ((state_r == S_PAD) && padc_r == pad - 2'd1);
    out_image_end = out_run_last && row_end && last_row;
  end

  // Column and row counters advance on the final byte of a run, so the run flags see the
  // position of the pixel that caused it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r <= '0; row_r <= '0; hidx_r <= '0; ch_r <= '0; padc_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          hidx_r <= '0; ch_r <= '0; padc_r <= '0;
          state_r <= (col_r == 0 && row_r == 0) ? S_HDR : S_WAIT;
        end
        S_HDR: if (fire) begin
          hidx_r <= hidx_r + 6'd1;
          if (hidx_r == 6'(HDR_LEN - 1)) state_r <= S_WAIT;
        end
        S_WAIT: if (sts.done) state_r <= S_PIX;
        S_PIX: if (fire) begin
          ch_r <= ch_r + 2'd1;
          if (ch_r == 2'd2) begin
            if (row_end && pad != 0) state_r <= S_PAD;
            else begin
              state_r <= S_IDLE;
              if (row_end) begin
                col_r <= '0;
                row_r <= last_row ? 12'd0 : row_r + 12'd1;
              end else col_r <= col_r + 12'd1;
            end
          end
        end
        S_PAD: if (fire) begin
          padc_r <= padc_r + 2'd1;
          if (padc_r == pad - 2'd1) begin
            state_r <= S_IDLE;
            col_r <= '0;
            row_r <= last_row ? 12'd0 : row_r + 12'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/jet_colormap_bmp_stream_writer_core.sv =====
// Top level: jet colormap 24-bit BMP byte stream writer.
//   channel | direction | payload
//   in_     | request   | in_sample (signed Q16.16)
//   out_    | result    | out_out_byte, out_run_last, out_image_end
//   cfg_    | write     | cfg_index, cfg_data
// Cycles: one byte per cycle out while out_ready is high. The colors of a request
// come from one setup step, then three bit-serial divisions in the datapath;
// the 54 header bytes of a new image go out while the colors are computed. Then 3 color
// bytes and the row pad follow, and the controller returns to idle.
// Reset: synchronous active low; counters zero, config registers to defaults.
// Stalls: out_ready low freezes the byte sequence; no new request taken
// until the previous sample's bytes are all delivered.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jet_colormap_bmp_stream_writer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_out_byte,
  output logic                 out_run_last,
  output logic                 out_image_end,
  input  logic                 cfg_we,
  input  logic [jcbw_pkg::IDX_W-1:0] cfg_index,
  input  logic [jcbw_pkg::CFG_W-1:0] cfg_data
);
  import jcbw_pkg::*;

  logic [12:0]        size_r;
  logic signed [31:0] min_r, max_r;
  logic [12:0]        n_sz;
  logic signed [31:0] sample_r;
  cmd_t cmd;
  sts_t sts;

  // Config registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 13'd256; min_r <= '0; max_r <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE: size_r <= cfg_data[12:0];
        REG_MIN:  min_r  <= cfg_data;
        REG_MAX:  max_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp size into 1..MAX_SIZE.
  assign n_sz = (size_r == 0) ? 13'd1 :
                (size_r > 13'(MAX_SIZE)) ? 13'(MAX_SIZE) : size_r;

  always_ff @(posedge clk) if (in_valid && in_ready) sample_r <= in_sample;

  jcbw_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .out_run_last, .out_image_end, .n_sz, .sts, .cmd
  );

  jcbw_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .sample(in_sample), .min_level(min_r),
    .max_level(max_r), .n_sz, .out_byte(out_out_byte)
  );

  logic unused;
  assign unused = ^sample_r;

  `ASSERT_IMPL(a_end_is_last, clk, rst_n, out_image_end, out_run_last)
  `ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)
endmodule
